[rtl/core/aes128_pkg.sv]
// ----------------------------------------------------------------------------
// aes128_pkg
// Shared types, constants and byte functions of the AES-128 encrypt pipeline.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned ROUND_COUNT = 10;
  localparam int unsigned BLOCK_W     = 128;
  localparam int unsigned HALF_W      = 64;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] GF_POLY = 8'h1b;

  typedef logic [BLOCK_W-1:0] block_t;

  // forward S-box
  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  // round constant for rounds 1..10
  function automatic logic [7:0] rcon(input int unsigned rnd);
    logic [7:0] r;
    case (rnd)
      1: r = 8'h01; 2: r = 8'h02; 3: r = 8'h04; 4: r = 8'h08; 5: r = 8'h10;
      6: r = 8'h20; 7: r = 8'h40; 8: r = 8'h80; 9: r = 8'h1b; 10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[BLOCK_W-1-8*i -: 8];
  endfunction

endpackage

[rtl/core/aes128_block_encrypt_unit.sv]
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// AES-128 block encryption, fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// channel | dir | data                                     | handshake
// in_     | in  | tdata[63:0] pt_high, [127:64] pt_low     | tvalid/tready
// out_    | out | tdata[63:0] ct_high, [127:64] ct_low     | tvalid/tready
// cfg_    | in  | wdata 64b, idx 0 key_high, 1 key_low     | wen
//
// Initial key add stage plus ten round stages; one block per cycle while
// the pipe is not held. All stages advance together; when the output stage
// is full and not taken, the whole pipe holds and in_tready drops, even if
// empty slots remain ahead. Reset clears valid bits and loads the default key.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit #(
  parameter int unsigned ROUNDS = aes128_pkg::ROUND_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [aes128_pkg::BLOCK_W-1:0]    in_tdata,  // pt_high, pt_low
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [aes128_pkg::BLOCK_W-1:0]    out_tdata, // ct_high, ct_low
  input  logic                              cfg_wen,
  input  logic [aes128_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [aes128_pkg::HALF_W-1:0]     cfg_wdata
);

  localparam int unsigned H = aes128_pkg::HALF_W;

  logic [H-1:0]       key_high_r, key_low_r;
  logic               vld   [ROUNDS+1];
  aes128_pkg::block_t st    [ROUNDS+1];
  aes128_pkg::block_t key   [ROUNDS+1];
  logic               adv;
  logic               v0_r;
  aes128_pkg::block_t st0_r, key0_r;
  aes128_pkg::block_t st0_nxt, key0_nxt;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= 64'h0001020304050607;
      key_low_r  <= 64'h08090a0b0c0d0e0f;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        aes128_pkg::REG_KEY_HIGH: key_high_r <= cfg_wdata;
        aes128_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: move unless the output holds a result not taken
  assign adv       = !vld[ROUNDS] || out_tready;
  assign in_tready = adv;

  // initial AddRoundKey stage
  assign key0_nxt = {key_high_r, key_low_r};
  assign st0_nxt  = {in_tdata[H-1:0], in_tdata[2*H-1:H]} ^ key0_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r  <= st0_nxt;
      key0_r <= key0_nxt;
    end
  end

  assign vld[0] = v0_r;
  assign st[0]  = st0_r;
  assign key[0] = key0_r;

  for (genvar g = 1; g <= ROUNDS; g++) begin : g_rnd
    aes128_round #(
      .RND      (g),
      .LAST_RND (g == ROUNDS)
    ) u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (vld[g-1]),
      .st_in   (st[g-1]),
      .key_in  (key[g-1]),
      .vld_out (vld[g]),
      .st_out  (st[g]),
      .key_out (key[g])
    );
  end

  assign out_tvalid = vld[ROUNDS];
  assign out_tdata  = {st[ROUNDS][H-1:0], st[ROUNDS][2*H-1:H]};

endmodule

[rtl/core/aes128_round.sv]
// ----------------------------------------------------------------------------
// aes128_round
// One cipher round plus key step, registered; stalls hold the stage.
// ----------------------------------------------------------------------------
module aes128_round #(
  parameter int unsigned RND      = 1,
  parameter bit          LAST_RND = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                vld_in,
  input  aes128_pkg::block_t  st_in,
  input  aes128_pkg::block_t  key_in,
  output logic                vld_out,
  output aes128_pkg::block_t  st_out,
  output aes128_pkg::block_t  key_out
);

  logic [7:0]         sb  [16];
  logic [7:0]         sr  [16];
  logic [7:0]         mc  [16];
  logic [7:0]         kb  [16];
  logic [7:0]         nk  [16];
  logic [7:0]         w   [4];
  aes128_pkg::block_t st_nxt, key_nxt;
  aes128_pkg::block_t st_r, key_r;
  logic               vld_r;

  // SubBytes and ShiftRows
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = aes128_pkg::sbox(aes128_pkg::get_byte(st_in, i));
      kb[i] = aes128_pkg::get_byte(key_in, i);
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sr[4*c+r] = sb[4*((c+r)%4)+r];
  end

  // MixColumns, bypassed in the final round
  always_comb begin
    logic [7:0] all;
    for (int c = 0; c < 4; c++) begin
      all = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      for (int r = 0; r < 4; r++) begin
        if (LAST_RND)
          mc[4*c+r] = sr[4*c+r];
        else
          mc[4*c+r] = sr[4*c+r] ^ all ^
                      aes128_pkg::xtime(sr[4*c+r] ^ sr[4*c+((r+1)%4)]);
      end
    end
  end

  // key expansion step
  always_comb begin
    w[0] = aes128_pkg::sbox(kb[13]) ^ aes128_pkg::rcon(RND);
    w[1] = aes128_pkg::sbox(kb[14]);
    w[2] = aes128_pkg::sbox(kb[15]);
    w[3] = aes128_pkg::sbox(kb[12]);
    for (int j = 0; j < 4; j++) begin
      nk[j]    = kb[j] ^ w[j];
      nk[4+j]  = kb[4+j] ^ nk[j];
      nk[8+j]  = kb[8+j] ^ nk[4+j];
      nk[12+j] = kb[12+j] ^ nk[8+j];
    end
    for (int i = 0; i < 16; i++) begin
      key_nxt[aes128_pkg::BLOCK_W-1-8*i -: 8] = nk[i];
      st_nxt[aes128_pkg::BLOCK_W-1-8*i -: 8]  = mc[i] ^ nk[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r  <= st_nxt;
      key_r <= key_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign key_out = key_r;

endmodule

[bench/aes128_encrypt_checker.sv]
// ----------------------------------------------------------------------------
// aes128_encrypt_checker
// Watches the request and result streams of the AES-128 encrypt unit, tracks
// the key register writes, computes the expected ciphertext of every accepted
// request in order and compares it with each accepted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_encrypt_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [aes128_pkg::BLOCK_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [aes128_pkg::BLOCK_W-1:0]   out_tdata,
  input  logic                             cfg_wen,
  input  logic [aes128_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [aes128_pkg::HALF_W-1:0]    cfg_wdata,
  output int                               fail_count,
  output int                               pending_count,
  output int                               cipher_count
);

  typedef logic [7:0] byte_arr_t [16];

  // Substitution table, filled once from the FIPS-197 listing
  logic [7:0] sub_tab [256];
  logic [7:0] rc_tab [11];

  logic [63:0] key_hi_q, key_lo_q;
  logic [127:0] cipher_q [$];

  initial begin
    logic [127:0] rows [16];
    rows[0]  = 128'h637c777bf26b6fc53001672bfed7ab76;
    rows[1]  = 128'hca82c97dfa5947f0add4a2af9ca472c0;
    rows[2]  = 128'hb7fd9326363ff7cc34a5e5f171d83115;
    rows[3]  = 128'h04c723c31896059a071280e2eb27b275;
    rows[4]  = 128'h09832c1a1b6e5aa0523bd6b329e32f84;
    rows[5]  = 128'h53d100ed20fcb15b6acbbe394a4c58cf;
    rows[6]  = 128'hd0efaafb434d338545f9027f503c9fa8;
    rows[7]  = 128'h51a3408f929d38f5bcb6da2110fff3d2;
    rows[8]  = 128'hcd0c13ec5f974417c4a77e3d645d1973;
    rows[9]  = 128'h60814fdc222a908846eeb814de5e0bdb;
    rows[10] = 128'he0323a0a4906245cc2d3ac629195e479;
    rows[11] = 128'he7c8376d8dd54ea96c56f4ea657aae08;
    rows[12] = 128'hba78252e1ca6b4c6e8dd741f4bbd8b8a;
    rows[13] = 128'h703eb5664803f60e613557b986c11d9e;
    rows[14] = 128'he1f8981169d98e949b1e87e9ce5528df;
    rows[15] = 128'h8ca1890dbfe6426841992d0fb054bb16;
    for (int i = 0; i < 256; i++) sub_tab[i] = rows[i / 16][127 - 8 * (i % 16) -: 8];
    rc_tab = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
               8'h1b, 8'h36};
  end

  function automatic logic [7:0] gf_mul2(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  // Full AES-128 encryption of one block under the current key
  function automatic logic [127:0] encrypt_block(input logic [127:0] pt,
                                                 input logic [127:0] key);
    byte_arr_t s, k, t;
    logic [7:0] w [4];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] ct;
    for (int i = 0; i < 16; i++) begin
      s[i] = pt[127 - 8 * i -: 8] ^ key[127 - 8 * i -: 8];
      k[i] = key[127 - 8 * i -: 8];
    end
    for (int rnd = 1; rnd <= aes128_pkg::ROUND_COUNT; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = sub_tab[s[i]];
      // row r rotates left by r columns
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4 * c + r] = s[4 * ((c + r) % 4) + r];
      s = t;
      if (rnd != aes128_pkg::ROUND_COUNT) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ all ^ gf_mul2(a0 ^ a1);
          s[4*c+1] = a1 ^ all ^ gf_mul2(a1 ^ a2);
          s[4*c+2] = a2 ^ all ^ gf_mul2(a2 ^ a3);
          s[4*c+3] = a3 ^ all ^ gf_mul2(a3 ^ a0);
        end
      end
      // key schedule: RotWord, SubWord, Rcon
      w[0] = sub_tab[k[13]] ^ rc_tab[rnd];
      w[1] = sub_tab[k[14]];
      w[2] = sub_tab[k[15]];
      w[3] = sub_tab[k[12]];
      for (int j = 0; j < 4; j++) begin
        k[j]      ^= w[j];
        k[4 + j]  ^= k[j];
        k[8 + j]  ^= k[4 + j];
        k[12 + j] ^= k[8 + j];
      end
      for (int i = 0; i < 16; i++) s[i] ^= k[i];
    end
    for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = s[i];
    return ct;
  endfunction

  assign pending_count = cipher_q.size();

  always @(posedge clk) begin
    logic [127:0] pt, want, got;
    if (!rst_n) begin
      key_hi_q     <= 64'h0001020304050607;
      key_lo_q     <= 64'h08090a0b0c0d0e0f;
      fail_count   <= 0;
      cipher_count <= 0;
      cipher_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        // tdata holds pt_high low, pt_low high; the cipher wants byte 0 first
        pt = {in_tdata[63:0], in_tdata[127:64]};
        want = encrypt_block(pt, {key_hi_q, key_lo_q});
        cipher_q.push_back({want[63:0], want[127:64]});
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        cipher_count <= cipher_count + 1;
        if (cipher_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with no request pending: %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = cipher_q.pop_front();
          if (want[63:0] !== got[63:0] || want[127:64] !== got[127:64]) begin
            if (fail_count < 10)
              $display("%0t: ciphertext mismatch high exp %h got %h, low exp %h got %h",
                       $realtime, want[63:0], got[63:0], want[127:64], got[127:64]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_wen) begin
        if (cfg_idx == aes128_pkg::REG_KEY_HIGH) key_hi_q <= cfg_wdata;
        else if (cfg_idx == aes128_pkg::REG_KEY_LOW) key_lo_q <= cfg_wdata;
      end
    end
  end

endmodule

[bench/tb_aes128_block_encrypt_unit.sv]
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt_unit
// Drives plaintext requests in bursts against a stalling result side, changes
// the key between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aes128_block_encrypt_unit;

  localparam int PIPE_LAT = 11;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;  // [63:0] pt_high, [127:64] pt_low
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;      // [63:0] ct_high, [127:64] ct_low
  logic         cfg_wen = 1'b0;
  logic [aes128_pkg::CFG_IDX_W-1:0] cfg_idx = aes128_pkg::REG_KEY_HIGH;
  logic [63:0]  cfg_wdata = '0;

  int fail_count, pending_count, cipher_count;
  int sent_count = 0;
  int key_writes = 0;
  bit drive_done = 1'b0;

  aes128_block_encrypt_unit u_dut (.*);

  aes128_encrypt_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_wen, .cfg_idx, .cfg_wdata,
    .fail_count, .pending_count, .cipher_count
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side stall pattern: alternates free and choppy stretches
  always @(posedge clk) begin
    int mode_left, mode;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 150);
    end
    mode_left--;
    case (mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // One request, with a random gap ahead of it when the burst has ended
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    static int burst_left = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {lo, hi};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Key write once the pipe has drained
  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
    cfg_wen <= 1'b1; cfg_idx <= aes128_pkg::REG_KEY_HIGH; cfg_wdata <= hi;
    @(posedge clk);
    cfg_idx <= aes128_pkg::REG_KEY_LOW; cfg_wdata <= lo;
    @(posedge clk);
    cfg_wen <= 1'b0;
    key_writes += 2;
    @(posedge clk);
  endtask

  initial begin
    logic [63:0] keys [5][2];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: FIPS-197 vector under the reset key, field extremes, then further keys
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('0, '0);
    send_block('1, '1);
    send_block('1, '0);
    send_block('0, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block('1, '1);
    write_key('0, '0);
    send_block('0, '0);
    send_block('1, '1);
    write_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);

    // Random phases over a set of keys, extremes included
    keys[0] = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f};
    keys[1] = '{'1, '1};
    keys[2] = '{'0, '0};
    keys[3] = '{rand64(), rand64()};
    keys[4] = '{rand64(), rand64()};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 5) write_key(keys[ph][0], keys[ph][1]);
      else write_key(rand64(), rand64());
      repeat (160) send_block(rand64(), rand64());
    end
    in_tvalid <= 1'b0;
    drive_done = 1'b1;
  end

  initial begin
    wait (drive_done);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LAT * 3) @(posedge clk);
    $display("%0d plaintext blocks sent, %0d ciphertexts checked, %0d key writes",
             sent_count, cipher_count, key_writes);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_aes128_block_encrypt_unit passed");
    else
      $display("tb_aes128_block_encrypt_unit failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_aes128_block_encrypt_unit failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/aes128_pkg.sv
rtl/core/aes128_round.sv
rtl/core/aes128_block_encrypt_unit.sv
bench/aes128_encrypt_checker.sv
bench/tb_aes128_block_encrypt_unit.sv
